/* rtl/core/tse_pkg.sv */
// Shared types and constants of the TFTP session engine.
// No dependencies; imported by every module of the block.
`default_nettype none

package tse_pkg;

  localparam int SESSIONS   = 4;
  localparam int SES_W      = 2;
  localparam int MAX_BLOCK  = 1468;
  localparam int MAX_WINDOW = 8;
  localparam int OQ_DEPTH   = 4;

  localparam logic [1:0] MODE_REQ  = 2'd0;
  localparam logic [1:0] MODE_PKT  = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;

  localparam logic [15:0] OP_RRQ  = 16'd1;
  localparam logic [15:0] OP_WRQ  = 16'd2;
  localparam logic [15:0] OP_DATA = 16'd3;
  localparam logic [15:0] OP_ACK  = 16'd4;
  localparam logic [15:0] OP_ERR  = 16'd5;

  localparam logic [1:0] CFG_ENABLE  = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_RETRY   = 2'd2;
  localparam logic [1:0] CFG_DALLY   = 2'd3;

  typedef enum logic [1:0] {
    KIND_REQ,
    KIND_PKT,
    KIND_TICK,
    KIND_NONE
  } kind_e;

  typedef enum logic [2:0] {
    ACT_OACK,
    ACT_DATA,
    ACT_ACK,
    ACT_ERR_SES,
    ACT_WRITE,
    ACT_CLOSED,
    ACT_ERR_REQ,
    ACT_ERR_PEER
  } act_e;

  typedef enum logic [1:0] {
    ERR_UNDEF,
    ERR_ILLEGAL,
    ERR_TID
  } err_e;

  typedef struct packed {
    logic [1:0]       mode;
    logic [SES_W-1:0] session;
    logic [15:0]      opcode;
    logic [15:0]      block;
    logic [10:0]      payload_len;
    logic [31:0]      peer_ip;
    logic [15:0]      peer_port;
    logic [10:0]      req_blksize;
    logic [3:0]       req_window;
    logic             req_has_opts;
    logic [31:0]      file_length;
  } item_t;

  typedef struct packed {
    kind_e kind;
    item_t item;
  } entry_t;

  typedef struct packed {
    act_e             act;
    logic [SES_W-1:0] sess;
    logic [15:0]      blk;
    logic [31:0]      off;
    logic [10:0]      cnt;
    err_e             kind;
    logic [10:0]      obs;
    logic [3:0]       ow;
    logic             last;
  } res_t;

  typedef struct packed {
    logic [2:0] readers;
    logic       writers;
  } status_t;

endpackage

`default_nettype wire

/* rtl/core/tse_front.sv */
// Front end: two-entry input queue that classifies each transaction by mode.
// Depends on tse_pkg.
`default_nettype none

module tse_front import tse_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire item_t  item_i,
  output logic        full_o,
  output logic        valid_o,
  output entry_t      entry_o,
  input  wire logic   pop_i
);

  entry_t     q_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  entry_t     ent;
  logic       do_push, do_pop;

  always_comb begin
    ent.item = item_i;
    case (item_i.mode)
      MODE_REQ:  ent.kind = KIND_REQ;
      MODE_PKT:  ent.kind = KIND_PKT;
      MODE_TICK: ent.kind = KIND_TICK;
      default:   ent.kind = KIND_NONE;
    endcase
  end

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign entry_o = q_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        q_q[wp_q] <= ent;
        wp_q      <= !wp_q;
      end
      if (do_pop) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

`default_nettype wire

/* rtl/core/tse_back.sv */
// Back end: session table, sequencer for the actions of one transaction, and
// the result queue. Depends on tse_pkg.
`default_nettype none

module tse_back import tse_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   valid_i,
  input  wire entry_t entry_i,
  output logic        pop_o,
  input  wire logic   cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [7:0] cfg_wdata_i,
  output logic        empty_o,
  output res_t        res_o,
  input  wire logic   pop_i,
  output status_t     status_o
);

  typedef enum logic [2:0] {
    PH_FREE, PH_OACK_RD, PH_READ, PH_OACK_WR, PH_WRITE, PH_DALLY
  } phase_e;

  typedef enum logic [3:0] {
    S_IDLE, S_REQ, S_PRE, S_PKT, S_ACK2, S_WIN, S_TICK, S_CLOSE, S_END
  } state_e;

  // config
  logic       en_q;
  logic [7:0] tmo_q, dally_cfg_q;
  logic [3:0] rlim_q;

  // session table
  phase_e      ph_q    [SESSIONS];
  logic [31:0] addr_q  [SESSIONS];
  logic [15:0] port_q  [SESSIONS];
  logic [10:0] bs_q    [SESSIONS];
  logic [3:0]  ws_q    [SESSIONS];
  logic [15:0] wf_q    [SESSIONS];
  logic [15:0] lbs_q   [SESSIONS];
  logic [31:0] wfp_q   [SESSIONS];
  logic [31:0] wb_q    [SESSIONS];
  logic        fin_q   [SESSIONS];
  logic [15:0] ne_q    [SESSIONS];
  logic [31:0] fsz_q   [SESSIONS];
  logic [7:0]  tk_q    [SESSIONS];
  logic [3:0]  rt_q    [SESSIONS];
  logic [7:0]  dl_q    [SESSIONS];
  logic [2:0]  rd_q;
  logic        wa_q;

  state_e           st_q;
  item_t            it_q;
  logic [SES_W-1:0] ws_s_q, tick_s_q, cs_q;
  logic             tret_q;
  logic [3:0]       i_q;
  logic [26:0]      prod_q;
  logic [15:0]      ackblk_q;
  res_t             pend_q;
  logic             pend_v_q;

  // result queue
  res_t       oq_q [OQ_DEPTH];
  logic [1:0] oq_wp_q, oq_rp_q;
  logic [2:0] oq_cnt_q;

  logic             can_emit, oq_pop, fr_found;
  logic [SES_W-1:0] fr_idx, ps;
  logic [15:0]      mul_a;
  logic [3:0]       fresh_rt;

  assign ps       = it_q.session;
  assign fresh_rt = (rlim_q == 4'd0) ? 4'd0 : rlim_q - 4'd1;
  assign can_emit = !pend_v_q || (oq_cnt_q != 3'(OQ_DEPTH));
  assign oq_pop   = pop_i && (oq_cnt_q != 3'd0);
  assign empty_o  = (oq_cnt_q == 3'd0);
  assign res_o    = oq_q[oq_rp_q];
  assign pop_o    = (st_q == S_IDLE) && valid_i;
  assign status_o = '{readers: rd_q, writers: wa_q};

  // lowest free session
  always_comb begin
    fr_found = 1'b0;
    fr_idx   = '0;
    for (int k = SESSIONS - 1; k >= 0; k--) begin
      if (ph_q[k] == PH_FREE) begin
        fr_found = 1'b1;
        fr_idx   = SES_W'(k);
      end
    end
  end

  assign mul_a = (ph_q[ps] == PH_READ) ? it_q.block - (wf_q[ps] - 16'd1)
                                       : it_q.block - 16'd1;

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * bs_q[ps];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin : seq
    logic             emit;
    res_t             r;
    logic             push;
    res_t             pd;
    logic [15:0]      blk, ws1, wblk;
    logic [31:0]      pos, diff;
    logic [10:0]      len, bsc;
    logic [3:0]       wsc;
    logic             wr, allow;
    logic [7:0]       tnext, dnext;
    logic [SES_W-1:0] s;
    state_e           st_n;
    logic [SES_W-1:0] ts_n;
    if (!rst_ni) begin
      en_q        <= 1'b1;
      tmo_q       <= 8'd5;
      rlim_q      <= 4'd3;
      dally_cfg_q <= 8'd3;
      for (int k = 0; k < SESSIONS; k++) ph_q[k] <= PH_FREE;
      rd_q     <= '0;
      wa_q     <= 1'b0;
      st_q     <= S_IDLE;
      pend_v_q <= 1'b0;
      oq_wp_q  <= '0;
      oq_rp_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      emit = 1'b0;
      r    = '0;
      push = 1'b0;
      pd   = pend_q;
      blk  = it_q.block;
      st_n = st_q;
      ts_n = tick_s_q;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ENABLE:  en_q        <= cfg_wdata_i[0];
          CFG_TIMEOUT: tmo_q       <= cfg_wdata_i;
          CFG_RETRY:   rlim_q      <= cfg_wdata_i[3:0];
          CFG_DALLY:   dally_cfg_q <= cfg_wdata_i;
          default:     ;
        endcase
      end

      case (st_q)
        S_IDLE: begin
          if (valid_i) begin
            it_q <= entry_i.item;
            case (entry_i.kind)
              KIND_REQ:  st_n = S_REQ;
              KIND_PKT:  st_n = S_PRE;
              KIND_TICK: begin
                ts_n = '0;
                st_n = S_TICK;
              end
              default:   st_n = S_END;
            endcase
          end
        end

        S_PRE: st_n = S_PKT;

        S_REQ: if (can_emit) begin
          wr    = (it_q.opcode == OP_WRQ);
          allow = wr ? (rd_q == 3'd0 && !wa_q)
                     : (!wa_q && rd_q < 3'(SESSIONS));
          s     = fr_idx;
          bsc   = (it_q.req_blksize < 11'd8) ? 11'd8 :
                  (it_q.req_blksize > 11'(MAX_BLOCK)) ? 11'(MAX_BLOCK) : it_q.req_blksize;
          wsc   = (it_q.req_window == 4'd0) ? 4'd1 :
                  (it_q.req_window > 4'(MAX_WINDOW)) ? 4'(MAX_WINDOW) : it_q.req_window;
          st_n  = S_END;
          if (!en_q) begin
            // disabled: silent
          end else if (it_q.opcode != OP_RRQ && it_q.opcode != OP_WRQ) begin
            emit = 1'b1; r.act = ACT_ERR_REQ; r.kind = ERR_ILLEGAL;
          end else if (!allow || !fr_found) begin
            emit = 1'b1; r.act = ACT_ERR_REQ; r.kind = ERR_UNDEF;
          end else begin
            addr_q[s] <= it_q.peer_ip;
            port_q[s] <= it_q.peer_port;
            bs_q[s]   <= bsc;
            ws_q[s]   <= wsc;
            wb_q[s]   <= '0;
            fin_q[s]  <= 1'b0;
            lbs_q[s]  <= '0;
            tk_q[s]   <= tmo_q;
            rt_q[s]   <= fresh_rt;
            wfp_q[s]  <= '0;
            r.sess    = s;
            if (!wr) begin
              rd_q     <= rd_q + 3'd1;
              wf_q[s]  <= 16'd1;
              fsz_q[s] <= it_q.file_length;
              ne_q[s]  <= '0;
              if (it_q.req_has_opts) begin
                ph_q[s] <= PH_OACK_RD;
                emit = 1'b1; r.act = ACT_OACK; r.obs = bsc; r.ow = wsc;
              end else begin
                ph_q[s] <= PH_READ;
                ws_s_q  <= s;
                tret_q  <= 1'b0;
                i_q     <= '0;
                st_n    = S_WIN;
              end
            end else begin
              wa_q     <= 1'b1;
              ne_q[s]  <= 16'd1;
              wf_q[s]  <= '0;
              fsz_q[s] <= '0;
              if (it_q.req_has_opts) begin
                ph_q[s] <= PH_OACK_WR;
                emit = 1'b1; r.act = ACT_OACK; r.obs = bsc; r.ow = wsc;
              end else begin
                ph_q[s] <= PH_WRITE;
                emit = 1'b1; r.act = ACT_ACK;
              end
            end
          end
        end

        S_PKT: if (can_emit) begin
          s      = ps;
          ws1    = wf_q[s] - 16'd1;
          r.sess = s;
          st_n   = S_END;
          if (ph_q[s] == PH_FREE) begin
            // not open
          end else if (it_q.peer_ip != addr_q[s] || it_q.peer_port != port_q[s]) begin
            emit = 1'b1; r.act = ACT_ERR_PEER; r.kind = ERR_TID;
          end else if (it_q.opcode == OP_ERR) begin
            cs_q   <= s;
            tret_q <= 1'b0;
            st_n   = S_CLOSE;
          end else begin
            case (ph_q[s])
              PH_DALLY: begin
                if (it_q.opcode == OP_DATA && blk == ne_q[s] - 16'd1) begin
                  emit = 1'b1; r.act = ACT_ACK; r.blk = blk;
                end
              end
              PH_OACK_RD: begin
                if (it_q.opcode == OP_ACK && blk == 16'd0) begin
                  ph_q[s] <= PH_READ;
                  tk_q[s] <= tmo_q;
                  rt_q[s] <= fresh_rt;
                  ws_s_q  <= s;
                  tret_q  <= 1'b0;
                  i_q     <= '0;
                  st_n    = S_WIN;
                end
              end
              PH_READ: begin
                if (it_q.opcode == OP_ACK && blk >= ws1) begin
                  tk_q[s] <= tmo_q;
                  rt_q[s] <= fresh_rt;
                  if (blk == lbs_q[s]) begin
                    if (fin_q[s]) begin
                      cs_q   <= s;
                      tret_q <= 1'b0;
                      st_n   = S_CLOSE;
                    end else begin
                      wfp_q[s] <= wfp_q[s] + wb_q[s];
                      wf_q[s]  <= blk + 16'd1;
                      ws_s_q   <= s;
                      tret_q   <= 1'b0;
                      i_q      <= '0;
                      st_n     = S_WIN;
                    end
                  end else if (blk >= wf_q[s] && blk < lbs_q[s]) begin
                    wfp_q[s] <= wfp_q[s] + {5'd0, prod_q};
                    wf_q[s]  <= blk + 16'd1;
                    ws_s_q   <= s;
                    tret_q   <= 1'b0;
                    i_q      <= '0;
                    st_n     = S_WIN;
                  end
                end
              end
              PH_OACK_WR, PH_WRITE: begin
                if (it_q.opcode == OP_DATA &&
                    (ph_q[s] == PH_WRITE || blk == 16'd1)) begin
                  // a short block in order moves the session to dally
                  ph_q[s] <= (blk == ne_q[s] && it_q.payload_len < bs_q[s]) ? PH_DALLY
                                                                              : PH_WRITE;
                  if (blk == ne_q[s] - 16'd1) begin
                    emit = 1'b1; r.act = ACT_ACK; r.blk = blk;
                  end else if (blk == ne_q[s]) begin
                    emit = 1'b1; r.act = ACT_WRITE; r.blk = blk;
                    r.off = {5'd0, prod_q}; r.cnt = it_q.payload_len;
                    ne_q[s]  <= ne_q[s] + 16'd1;
                    tk_q[s]  <= tmo_q;
                    rt_q[s]  <= fresh_rt;
                    ackblk_q <= blk;
                    if (it_q.payload_len < bs_q[s]) begin
                      dl_q[s] <= dally_cfg_q;
                    end
                    st_n = S_ACK2;
                  end
                end
              end
              default: ;
            endcase
          end
        end

        S_ACK2: if (can_emit) begin
          emit = 1'b1; r.act = ACT_ACK; r.sess = ps; r.blk = ackblk_q;
          st_n = S_END;
        end

        // one data block per cycle while the result queue has room
        S_WIN: if (can_emit) begin
          s    = ws_s_q;
          wblk = wf_q[s] + {12'd0, i_q};
          pos  = wfp_q[s] + (i_q == 4'd0 ? 32'd0 : wb_q[s]);
          diff = fsz_q[s] - pos;
          len  = (pos < fsz_q[s]) ? ((diff > {21'd0, bs_q[s]}) ? bs_q[s] : diff[10:0])
                                  : 11'd0;
          emit = 1'b1; r.act = ACT_DATA; r.sess = s; r.blk = wblk; r.off = pos; r.cnt = len;
          wb_q[s]  <= (i_q == 4'd0 ? 32'd0 : wb_q[s]) + {21'd0, len};
          lbs_q[s] <= wblk;
          fin_q[s] <= (len < bs_q[s]);
          i_q      <= i_q + 4'd1;
          if (len < bs_q[s] || i_q + 4'd1 == ws_q[s]) begin
            if (!tret_q) st_n = S_END;
            else if (tick_s_q == SES_W'(SESSIONS - 1)) st_n = S_END;
            else begin
              ts_n = tick_s_q + 1'b1;
              st_n = S_TICK;
            end
          end
        end

        // walk the sessions, one per cycle unless the result queue is full or a close or window comes between
        S_TICK: if (can_emit) begin
          s      = tick_s_q;
          tnext  = (tk_q[s] != 8'd0) ? tk_q[s] - 8'd1 : 8'd0;
          dnext  = (dl_q[s] != 8'd0) ? dl_q[s] - 8'd1 : 8'd0;
          r.sess = s;
          if (tick_s_q == SES_W'(SESSIONS - 1)) st_n = S_END;
          else ts_n = tick_s_q + 1'b1;
          if (ph_q[s] == PH_FREE) begin
            // nothing
          end else if (ph_q[s] == PH_DALLY) begin
            dl_q[s] <= dnext;
            if (dnext == 8'd0) begin
              cs_q   <= s;
              tret_q <= 1'b1;
              ts_n   = tick_s_q;
              st_n   = S_CLOSE;
            end
          end else begin
            if (tnext == 8'd0) begin
              if (rt_q[s] == 4'd0) begin
                tk_q[s] <= tnext;
                emit = 1'b1; r.act = ACT_ERR_SES; r.kind = ERR_UNDEF;
                cs_q   <= s;
                tret_q <= 1'b1;
                ts_n   = tick_s_q;
                st_n   = S_CLOSE;
              end else begin
                rt_q[s] <= rt_q[s] - 4'd1;
                tk_q[s] <= tmo_q;
                case (ph_q[s])
                  PH_OACK_RD, PH_OACK_WR: begin
                    emit = 1'b1; r.act = ACT_OACK; r.obs = bs_q[s]; r.ow = ws_q[s];
                  end
                  PH_READ: begin
                    ws_s_q <= s;
                    tret_q <= 1'b1;
                    i_q    <= '0;
                    ts_n   = tick_s_q;
                    st_n   = S_WIN;
                  end
                  PH_WRITE: begin
                    emit = 1'b1; r.act = ACT_ACK; r.blk = ne_q[s] - 16'd1;
                  end
                  default: ;
                endcase
              end
            end else begin
              tk_q[s] <= tnext;
            end
          end
        end

        S_CLOSE: if (can_emit) begin
          s = cs_q;
          emit = 1'b1; r.act = ACT_CLOSED; r.sess = s;
          if (ph_q[s] == PH_OACK_RD || ph_q[s] == PH_READ) begin
            if (rd_q != 3'd0) rd_q <= rd_q - 3'd1;
          end else begin
            wa_q <= 1'b0;
          end
          ph_q[s] <= PH_FREE;
          if (!tret_q) st_n = S_END;
          else if (tick_s_q == SES_W'(SESSIONS - 1)) st_n = S_END;
          else begin
            ts_n = tick_s_q + 1'b1;
            st_n = S_TICK;
          end
        end

        // flush the held result, marked last
        S_END: begin
          if (!pend_v_q) st_n = S_IDLE;
          else if (oq_cnt_q != 3'(OQ_DEPTH)) begin
            push     = 1'b1;
            pd.last  = 1'b1;
            pend_v_q <= 1'b0;
            st_n     = S_IDLE;
          end
        end

        default: st_n = S_IDLE;
      endcase

      st_q     <= st_n;
      tick_s_q <= ts_n;

      // a new result pushes the held one out, not last
      if (emit) begin
        if (pend_v_q) begin
          push    = 1'b1;
          pd.last = 1'b0;
        end
        r.last   = 1'b0;
        pend_q   <= r;
        pend_v_q <= 1'b1;
      end

      if (push) begin
        oq_q[oq_wp_q] <= pd;
        oq_wp_q       <= oq_wp_q + 2'd1;
      end
      if (oq_pop) oq_rp_q <= oq_rp_q + 2'd1;
      oq_cnt_q <= oq_cnt_q + {2'd0, push} - {2'd0, oq_pop};
    end
  end

endmodule

`default_nettype wire

/* rtl/core/tftp_session_engine.sv */
// Top level of the TFTP session engine: input queue, session back end, ports.
// Depends on tse_pkg, tse_front and tse_back.
`default_nettype none

// TFTP server session table for four sessions with blksize and windowsize
// options. Items enter through a two-deep queue (push/full) and results leave
// through a four-deep queue (empty/pop); last marks the final result of each
// item. The back end handles one item at a time and produces at most one
// result per cycle. A request may open a read straight into a window, a
// session packet may send the next window, and a tick walks the four
// sessions in turn, retransmitting or closing where a session needs it.
// Configuration writes take effect at once and should be made while the
// block is idle. Stalls on the result side hold the back end but not the
// input queue.

module tftp_session_engine import tse_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  mode_i,
  input  wire logic [1:0]  session_i,
  input  wire logic [15:0] opcode_i,
  input  wire logic [15:0] block_i,
  input  wire logic [10:0] payload_len_i,
  input  wire logic [31:0] peer_ip_i,
  input  wire logic [15:0] peer_port_i,
  input  wire logic [10:0] req_blksize_i,
  input  wire logic [3:0]  req_window_i,
  input  wire logic        req_has_opts_i,
  input  wire logic [31:0] file_length_i,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [7:0]  cfg_wdata_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [2:0]       action_o,
  output logic [1:0]       session_out_o,
  output logic [15:0]      block_out_o,
  output logic [31:0]      byte_offset_o,
  output logic [10:0]      byte_count_o,
  output logic [1:0]       error_kind_o,
  output logic [10:0]      oack_blksize_o,
  output logic [3:0]       oack_window_o,
  output logic             last_o
);

  item_t   item;
  entry_t  entry;
  logic    f_valid, f_pop;
  res_t    res;
  status_t status;

  assign item = '{mode: mode_i, session: session_i, opcode: opcode_i, block: block_i,
                  payload_len: payload_len_i, peer_ip: peer_ip_i,
                  peer_port: peer_port_i, req_blksize: req_blksize_i,
                  req_window: req_window_i, req_has_opts: req_has_opts_i,
                  file_length: file_length_i};

  // front: queue and classification
  tse_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (item),
    .full_o  (full),
    .valid_o (f_valid),
    .entry_o (entry),
    .pop_i   (f_pop)
  );

  // back: session table, sequencer and result queue
  tse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (f_valid),
    .entry_i     (entry),
    .pop_o       (f_pop),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .empty_o     (empty),
    .res_o       (res),
    .pop_i       (pop),
    .status_o    (status)
  );

  assign action_o       = res.act;
  assign session_out_o  = res.sess;
  assign block_out_o    = res.blk;
  assign byte_offset_o  = res.off;
  assign byte_count_o   = res.cnt;
  assign error_kind_o   = res.kind;
  assign oack_blksize_o = res.obs;
  assign oack_window_o  = res.ow;
  assign last_o         = res.last;

  // readers and the writer exclude each other
  a_rw_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(status.writers && status.readers != 3'd0))
    else $error("reader and writer sessions open together");

  // reader count never exceeds the table size
  a_rd_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.readers <= 3'(SESSIONS))
    else $error("reader count out of range");

  // a new writer can only appear while no readers are open
  a_wr_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(status.writers) |-> $past(status.readers) == 3'd0)
    else $error("writer opened while readers active");

endmodule

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench of tftp_session_engine: directed and random traffic.
// Depends on tse_pkg and the RTL of the engine; needs no files or arguments.
`timescale 1ns / 100ps

module tb;
  import tse_pkg::*;

  localparam int LIMIT_CYCLES = 600000;
  localparam int SETTLE       = 60;

  typedef enum logic [2:0] {
    PH_FREE, PH_OACK_RD, PH_READ, PH_OACK_WR, PH_WRITE, PH_DALLY
  } phase_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  item_t drv = '0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_idx = CFG_ENABLE;
  logic [7:0] cfg_wdata = '0;
  logic [2:0] action_o;
  logic [1:0] session_out_o, error_kind_o;
  logic [15:0] block_out_o;
  logic [31:0] byte_offset_o;
  logic [10:0] byte_count_o, oack_blksize_o;
  logic [3:0] oack_window_o;
  logic last_o;

  int errors = 0;
  int cycles = 0;
  int hold_cycles = 0;   // long stall of the result side, counted by the drain process
  bit steady = 1'b0;     // no random gaps on either side while set

  tftp_session_engine u_dut (
    .clk_i, .rst_ni, .push, .full,
    .mode_i(drv.mode), .session_i(drv.session), .opcode_i(drv.opcode),
    .block_i(drv.block), .payload_len_i(drv.payload_len), .peer_ip_i(drv.peer_ip),
    .peer_port_i(drv.peer_port), .req_blksize_i(drv.req_blksize),
    .req_window_i(drv.req_window), .req_has_opts_i(drv.req_has_opts),
    .file_length_i(drv.file_length),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .empty, .pop, .action_o, .session_out_o, .block_out_o, .byte_offset_o,
    .byte_count_o, .error_kind_o, .oack_blksize_o, .oack_window_o, .last_o
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Session table mirror. Updated at the edge each transaction is accepted, so
  // stimulus built after an accept always sees current state.
  // ---------------------------------------------------------------------------
  logic        cfg_en = 1'b1;
  logic [7:0]  cfg_tmo = 8'd5;
  logic [3:0]  cfg_retry = 4'd3;
  logic [7:0]  cfg_dally = 8'd3;

  phase_e      ses_ph[SESSIONS] = '{default: PH_FREE};
  logic [31:0] ses_ip[SESSIONS];
  logic [15:0] ses_port[SESSIONS];
  logic [10:0] ses_bsz[SESSIONS];
  logic [3:0]  ses_win[SESSIONS];
  logic [15:0] ses_wfirst[SESSIONS];
  logic [15:0] ses_lastblk[SESSIONS];
  logic [31:0] ses_wpos[SESSIONS];
  logic [31:0] ses_wbytes[SESSIONS];
  logic        ses_final[SESSIONS];
  logic [15:0] ses_next[SESSIONS];
  logic [31:0] ses_fsize[SESSIONS];
  logic [7:0]  ses_ticks[SESSIONS];
  logic [3:0]  ses_retries[SESSIONS];
  logic [7:0]  ses_dally[SESSIONS];
  int          readers = 0;
  int          writers = 0;
  int          opened = 0;   // session taken by the latest request

  res_t batch[$];             // actions of the transaction being predicted
  res_t pending_actions[$];   // actions still owed by the engine

  function automatic void emit(act_e a, int s, logic [15:0] b, logic [31:0] o,
                               logic [10:0] c, err_e k, logic [10:0] obs,
                               logic [3:0] ow);
    res_t r;
    if (batch.size() >= 32) return;
    r.act = a; r.sess = s[1:0]; r.blk = b; r.off = o; r.cnt = c; r.kind = k;
    r.obs = obs; r.ow = ow; r.last = 1'b0;
    batch.push_back(r);
  endfunction

  function automatic void restart_timer(int s);
    ses_ticks[s] = cfg_tmo;
    ses_retries[s] = (cfg_retry > 0) ? cfg_retry - 4'd1 : 4'd0;
  endfunction

  function automatic void close_session(int s);
    if (ses_ph[s] == PH_FREE) return;
    if (ses_ph[s] inside {PH_OACK_RD, PH_READ}) begin
      if (readers > 0) readers--;
    end else if (writers > 0) begin
      writers--;
    end
    ses_ph[s] = PH_FREE;
    emit(ACT_CLOSED, s, 0, 0, 0, ERR_UNDEF, 0, 0);
  endfunction

  function automatic void send_window(int s);
    logic [15:0] blk;
    logic [31:0] pos, len;
    ses_wbytes[s] = 0;
    ses_final[s] = 1'b0;
    for (int i = 0; i < ses_win[s] && !ses_final[s]; i++) begin
      blk = ses_wfirst[s] + 16'(i);
      pos = ses_wpos[s] + ses_wbytes[s];
      len = 0;
      if (pos < ses_fsize[s]) begin
        len = ses_fsize[s] - pos;
        if (len > ses_bsz[s]) len = ses_bsz[s];
      end
      ses_wbytes[s] = ses_wbytes[s] + len;
      if (len < ses_bsz[s]) ses_final[s] = 1'b1;
      emit(ACT_DATA, s, blk, pos, len[10:0], ERR_UNDEF, 0, 0);
      ses_lastblk[s] = blk;
    end
  endfunction

  function automatic void send_oack(int s);
    emit(ACT_OACK, s, 0, 0, 0, ERR_UNDEF, ses_bsz[s], ses_win[s]);
  endfunction

  function automatic void open_session(item_t it);
    bit wr;
    int s;
    logic [10:0] bs;
    logic [3:0] ws;
    if (!cfg_en) return;
    if (it.opcode != OP_RRQ && it.opcode != OP_WRQ) begin
      emit(ACT_ERR_REQ, 0, 0, 0, 0, ERR_ILLEGAL, 0, 0);
      return;
    end
    wr = (it.opcode == OP_WRQ);
    s = -1;
    if (wr ? (readers == 0 && writers == 0) : (writers == 0 && readers < SESSIONS))
      for (int i = SESSIONS - 1; i >= 0; i--)
        if (ses_ph[i] == PH_FREE) s = i;
    if (s < 0) begin
      emit(ACT_ERR_REQ, 0, 0, 0, 0, ERR_UNDEF, 0, 0);
      return;
    end
    bs = it.req_blksize;
    if (bs < 8) bs = 8;
    if (bs > MAX_BLOCK) bs = MAX_BLOCK;
    ws = it.req_window;
    if (ws < 1) ws = 1;
    if (ws > MAX_WINDOW) ws = MAX_WINDOW;
    opened = s;
    ses_ip[s] = it.peer_ip;
    ses_port[s] = it.peer_port;
    ses_bsz[s] = bs;
    ses_win[s] = ws;
    ses_wbytes[s] = 0;
    ses_final[s] = 1'b0;
    ses_lastblk[s] = 0;
    ses_wpos[s] = 0;
    restart_timer(s);
    if (!wr) begin
      readers++;
      ses_wfirst[s] = 1;
      ses_fsize[s] = it.file_length;
      ses_next[s] = 0;
      if (it.req_has_opts) begin
        ses_ph[s] = PH_OACK_RD;
        send_oack(s);
      end else begin
        ses_ph[s] = PH_READ;
        send_window(s);
      end
    end else begin
      writers = 1;
      ses_next[s] = 1;
      ses_wfirst[s] = 0;
      ses_fsize[s] = 0;
      if (it.req_has_opts) begin
        ses_ph[s] = PH_OACK_WR;
        send_oack(s);
      end else begin
        ses_ph[s] = PH_WRITE;
        emit(ACT_ACK, s, 0, 0, 0, ERR_UNDEF, 0, 0);
      end
    end
  endfunction

  function automatic void take_data(int s, logic [15:0] blk, logic [10:0] plen);
    logic [15:0] prev, bm1;
    logic [31:0] off;
    prev = ses_next[s] - 16'd1;
    if (blk == prev) begin
      emit(ACT_ACK, s, blk, 0, 0, ERR_UNDEF, 0, 0);
      return;
    end
    if (blk != ses_next[s]) return;
    bm1 = blk - 16'd1;
    off = 32'(bm1) * 32'(ses_bsz[s]);
    emit(ACT_WRITE, s, blk, off, plen, ERR_UNDEF, 0, 0);
    ses_next[s] = ses_next[s] + 16'd1;
    restart_timer(s);
    emit(ACT_ACK, s, blk, 0, 0, ERR_UNDEF, 0, 0);
    if (plen < ses_bsz[s]) begin
      ses_ph[s] = PH_DALLY;
      ses_dally[s] = cfg_dally;
    end
  endfunction

  function automatic void session_packet(item_t it);
    int s;
    logic [15:0] blk, ws1, d;
    s = it.session;
    blk = it.block;
    if (ses_ph[s] == PH_FREE) return;
    if (it.peer_ip != ses_ip[s] || it.peer_port != ses_port[s]) begin
      emit(ACT_ERR_PEER, s, 0, 0, 0, ERR_TID, 0, 0);
      return;
    end
    if (it.opcode == OP_ERR) begin
      close_session(s);
      return;
    end
    case (ses_ph[s])
      PH_DALLY: begin
        if (it.opcode == OP_DATA && blk == ses_next[s] - 16'd1)
          emit(ACT_ACK, s, blk, 0, 0, ERR_UNDEF, 0, 0);
      end
      PH_OACK_RD: begin
        if (it.opcode == OP_ACK && blk == 0) begin
          ses_ph[s] = PH_READ;
          send_window(s);
          restart_timer(s);
        end
      end
      PH_READ: begin
        ws1 = ses_wfirst[s] - 16'd1;
        if (it.opcode == OP_ACK && blk >= ws1) begin
          restart_timer(s);
          if (blk == ses_lastblk[s]) begin
            if (ses_final[s]) begin
              close_session(s);
            end else begin
              ses_wpos[s] = ses_wpos[s] + ses_wbytes[s];
              ses_wfirst[s] = blk + 16'd1;
              send_window(s);
            end
          end else if (blk >= ses_wfirst[s] && blk < ses_lastblk[s]) begin
            // partial acknowledgement: resume just after the acknowledged block
            d = blk - ws1;
            ses_wpos[s] = ses_wpos[s] + 32'(d) * 32'(ses_bsz[s]);
            ses_wfirst[s] = blk + 16'd1;
            send_window(s);
          end
        end
      end
      PH_OACK_WR: begin
        if (it.opcode == OP_DATA && blk == 1) begin
          ses_ph[s] = PH_WRITE;
          take_data(s, blk, it.payload_len);
        end
      end
      PH_WRITE: begin
        if (it.opcode == OP_DATA) take_data(s, blk, it.payload_len);
      end
      default: ;
    endcase
  endfunction

  function automatic void timer_tick();
    for (int s = 0; s < SESSIONS; s++) begin
      if (ses_ph[s] == PH_FREE) continue;
      if (ses_ph[s] == PH_DALLY) begin
        if (ses_dally[s] > 0) ses_dally[s]--;
        if (ses_dally[s] == 0) close_session(s);
        continue;
      end
      if (ses_ticks[s] > 0) ses_ticks[s]--;
      if (ses_ticks[s] > 0) continue;
      if (ses_retries[s] == 0) begin
        emit(ACT_ERR_SES, s, 0, 0, 0, ERR_UNDEF, 0, 0);
        close_session(s);
        continue;
      end
      ses_retries[s]--;
      ses_ticks[s] = cfg_tmo;
      case (ses_ph[s])
        PH_OACK_RD, PH_OACK_WR: send_oack(s);
        PH_READ:                send_window(s);
        PH_WRITE: emit(ACT_ACK, s, ses_next[s] - 16'd1, 0, 0, ERR_UNDEF, 0, 0);
        default: ;
      endcase
    end
  endfunction

  function automatic void predict_actions(item_t it);
    batch.delete();
    case (it.mode)
      MODE_REQ:  open_session(it);
      MODE_PKT:  session_packet(it);
      MODE_TICK: timer_tick();
      default: ;
    endcase
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) pending_actions.push_back(batch[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Item builders. Fields a transaction does not use still carry random bits.
  // ---------------------------------------------------------------------------
  function automatic item_t noise_item();
    item_t it;
    it.mode = 2'($urandom);
    it.session = 2'($urandom);
    it.opcode = 16'($urandom);
    it.block = 16'($urandom);
    it.payload_len = 11'($urandom_range(0, MAX_BLOCK));
    it.peer_ip = $urandom;
    it.peer_port = 16'($urandom);
    it.req_blksize = 11'($urandom);
    it.req_window = 4'($urandom);
    it.req_has_opts = 1'($urandom);
    it.file_length = $urandom;
    return it;
  endfunction

  function automatic item_t req_item(logic [15:0] op, logic [10:0] bs, logic [3:0] ws,
                                     logic opts, logic [31:0] flen);
    item_t it;
    it = noise_item();
    it.mode = MODE_REQ;
    it.opcode = op;
    it.req_blksize = bs;
    it.req_window = ws;
    it.req_has_opts = opts;
    it.file_length = flen;
    return it;
  endfunction

  function automatic item_t pkt_item(int s, logic [15:0] op, logic [15:0] blk,
                                     logic [10:0] plen);
    item_t it;
    it = noise_item();
    it.mode = MODE_PKT;
    it.session = s[1:0];
    it.opcode = op;
    it.block = blk;
    it.payload_len = plen;
    if (ses_ph[s] != PH_FREE) begin
      it.peer_ip = ses_ip[s];
      it.peer_port = ses_port[s];
    end
    return it;
  endfunction

  function automatic item_t tick_item();
    item_t it;
    it = noise_item();
    it.mode = MODE_TICK;
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: one transaction per call, random gap first
  // ---------------------------------------------------------------------------
  task automatic offer(item_t it);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    drv <= it;
    do @(posedge clk_i); while (full);
    predict_actions(it);
  endtask

  // Quiet the input and wait for the engine to drain, plus its walk time
  task automatic settle();
    push <= 1'b0;
    while (pending_actions.size() > 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic program_regs(logic en, logic [7:0] tmo, logic [3:0] rl, logic [7:0] dal);
    settle();
    cfg_we <= 1'b1;
    cfg_idx <= CFG_ENABLE;  cfg_wdata <= 8'(en);  @(posedge clk_i); cfg_en = en;
    cfg_idx <= CFG_TIMEOUT; cfg_wdata <= tmo;     @(posedge clk_i); cfg_tmo = tmo;
    cfg_idx <= CFG_RETRY;   cfg_wdata <= 8'(rl);  @(posedge clk_i); cfg_retry = rl;
    cfg_idx <= CFG_DALLY;   cfg_wdata <= dal;     @(posedge clk_i); cfg_dally = dal;
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random pop stalls, an optional long hold, field-by-field check
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  initial begin : drain
    int stall;
    res_t want;
    @(posedge rst_ni);
    forever begin
      if (hold_cycles > 0) begin
        pop <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end
      stall = steady ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      if (pending_actions.size() == 0) begin
        $error("unexpected action %0d on session %0d", action_o, session_out_o);
        errors++;
      end else begin
        want = pending_actions.pop_front();
        check_field("action", want.act, action_o);
        check_field("session_out", want.sess, session_out_o);
        check_field("block_out", want.blk, block_out_o);
        check_field("byte_offset", want.off, byte_offset_o);
        check_field("byte_count", want.cnt, byte_count_o);
        check_field("error_kind", want.kind, error_kind_o);
        check_field("oack_blksize", want.obs, oack_blksize_o);
        check_field("oack_window", want.ow, oack_window_o);
        check_field("last", want.last, last_o);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Bad opcode, saturated options, windowed read with a spoofed packet,
  // empty file, client error.
  task automatic test_read_basics();
    int s;
    offer(req_item(16'hFFFF, 11'd512, 4'd1, 1'b0, 32'd0));
    offer(req_item(OP_RRQ, 11'd0, 4'd15, 1'b1, 32'd20));
    s = opened;
    offer(pkt_item(s, OP_ACK, 16'd0, 11'd0));
    begin
      item_t spoof;
      spoof = pkt_item(s, OP_ACK, 16'd3, 11'd0);
      spoof.peer_port = ~spoof.peer_port;
      offer(spoof);
    end
    offer(pkt_item(s, OP_ACK, 16'd3, 11'd0));
    offer(req_item(OP_RRQ, 11'h7FF, 4'd0, 1'b0, 32'd0));
    offer(pkt_item(opened, OP_ERR, 16'd0, 11'd0));
    // partial ack in a window, then full file read out
    offer(req_item(OP_RRQ, 11'd8, 4'd4, 1'b0, 32'd50));
    s = opened;
    offer(pkt_item(s, OP_ACK, 16'd2, 11'd0));
    offer(pkt_item(s, OP_ACK, ses_lastblk[s], 11'd0));
    offer(pkt_item(s, OP_ACK, ses_lastblk[s], 11'd0));
  endtask

  // One writer excludes everyone; duplicates are re-acknowledged; dally ends it
  task automatic test_write_dally();
    int s;
    offer(req_item(OP_WRQ, 11'd8, 4'd2, 1'b1, $urandom));
    s = opened;
    offer(req_item(OP_WRQ, 11'd8, 4'd1, 1'b0, 32'd0));
    offer(req_item(OP_RRQ, 11'd8, 4'd1, 1'b0, 32'd9));
    offer(pkt_item(s, OP_DATA, 16'd1, 11'd8));
    offer(pkt_item(s, OP_DATA, 16'd1, 11'd8));
    offer(pkt_item(s, OP_DATA, 16'd2, 11'd3));
    offer(pkt_item(s, OP_DATA, 16'd2, 11'd3));
    repeat (3) offer(tick_item());
  endtask

  // All four readers, a fifth refused, then silence until everyone times out
  task automatic test_timeouts();
    item_t odd;
    repeat (5) offer(req_item(OP_RRQ, 11'd16, 4'd2, 1'($urandom), 32'd100));
    repeat (16) offer(tick_item());
    odd = tick_item();
    odd.mode = 2'd3;
    offer(odd);
    offer(pkt_item(2, OP_ACK, 16'd1, 11'd0));
  endtask

  task automatic test_disabled();
    program_regs(1'b0, 8'd5, 4'd3, 8'd3);
    offer(req_item(OP_RRQ, 11'd512, 4'd1, 1'b0, 32'd10));
    offer(req_item(OP_WRQ, 11'd512, 4'd1, 1'b1, 32'd10));
  endtask

  // Result side held for a long stretch while full windows keep arriving
  task automatic test_backpressure();
    hold_cycles = 400;
    repeat (4) offer(req_item(OP_RRQ, 11'd8, 4'd8, 1'b0, 32'd100000));
    repeat (6) offer(tick_item());
    for (int s = 0; s < SESSIONS; s++)
      offer(pkt_item(s, OP_ERR, 16'd0, 11'd0));
  endtask

  function automatic item_t random_request();
    int r;
    logic [15:0] op;
    logic [10:0] bs;
    logic [31:0] flen;
    r = $urandom_range(0, 9);
    op = (r < 6) ? OP_RRQ : (r < 9) ? OP_WRQ : 16'($urandom);
    r = $urandom_range(0, 19);
    bs = (r < 14) ? 11'($urandom_range(8, 64)) :
         (r < 17) ? 11'($urandom_range(8, MAX_BLOCK)) : 11'($urandom);
    r = $urandom_range(0, 19);
    flen = (r < 15) ? $urandom_range(0, 300) : (r < 18) ? $urandom_range(0, 5000) : $urandom;
    return req_item(op, bs, 4'($urandom), 1'($urandom), flen);
  endfunction

  // Mostly protocol-correct traffic on live sessions, with noise mixed in
  function automatic item_t random_item();
    int r, s;
    logic [15:0] blk;
    logic [10:0] plen;
    item_t it;
    r = $urandom_range(0, 99);
    if (r < 3) return noise_item();
    if (r < 20) return tick_item();
    if (r < 35) return random_request();
    s = $urandom_range(0, SESSIONS - 1);
    if (ses_ph[s] == PH_FREE)
      return ($urandom_range(0, 3) != 0) ? random_request() : pkt_item(s, OP_ACK, 1, 0);
    r = $urandom_range(0, 9);
    plen = ($urandom_range(0, 2) != 0) ? ses_bsz[s] : 11'($urandom_range(0, ses_bsz[s]));
    case (ses_ph[s])
      PH_OACK_RD: it = pkt_item(s, OP_ACK, (r < 8) ? 16'd0 : 16'($urandom), 0);
      PH_READ: begin
        if (r < 6) blk = ses_lastblk[s];
        else if (r < 8) blk = ses_wfirst[s] + 16'($urandom_range(0, ses_win[s] - 1));
        else if (r < 9) blk = ses_wfirst[s] - 16'd1;
        else blk = 16'($urandom);
        it = pkt_item(s, OP_ACK, blk, 0);
      end
      PH_OACK_WR, PH_WRITE: begin
        blk = (r < 7) ? ses_next[s] : (r < 9) ? ses_next[s] - 16'd1 : 16'($urandom);
        it = pkt_item(s, OP_DATA, blk, plen);
      end
      default: it = pkt_item(s, OP_DATA, ses_next[s] - 16'd1, plen);
    endcase
    r = $urandom_range(0, 99);
    if (r < 8) it.peer_ip[$urandom_range(0, 31)] ^= 1'b1;
    else if (r < 12) it.opcode = OP_ERR;
    else if (r < 16) it.opcode = 16'($urandom);
    return it;
  endfunction

  task automatic test_random(int count);
    repeat (count) begin
      steady = ($urandom_range(0, 7) == 0);
      offer(random_item());
    end
    steady = 1'b0;
  endtask

  initial begin : run
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_read_basics();
    test_write_dally();
    test_timeouts();
    test_disabled();
    program_regs(1'b1, 8'd5, 4'd3, 8'd3);
    test_backpressure();

    test_random(55);
    program_regs(1'b1, 8'd1, 4'd0, 8'd1);    // fastest timeout, retry zero
    test_random(55);
    program_regs(1'b1, 8'd255, 4'd15, 8'd255);
    test_random(55);
    program_regs(1'b1, 8'd3, 4'd2, 8'd2);
    test_random(55);

    settle();
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
